/* hdl/svpwm_pkg.sv */
// Package for the space vector PWM modulator.
// Holds fixed-point constants and sector codes; depends on nothing.
`default_nettype none
package svpwm_pkg;
	// sqrt(3) in Q28, positive, as a signed 30-bit constant.
	localparam logic signed [29:0] SQRT3_Q28 = 30'sd464943848;
	localparam int unsigned NUM_SHIFT = 29;
	localparam logic [15:0] PERIOD_RESET = 16'd1000;

	localparam logic [2:0] SEC_NONE = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;
	localparam logic [2:0] SEC_6 = 3'd6;
endpackage
`default_nettype wire

/* hdl/space_vector_pwm_modulator.sv */
// Top level of the symmetric space vector PWM modulator.
// Depends on svpwm_pkg for constants and sector codes.
`default_nettype none
// A voltage vector is taken on every clock edge where start is high; busy never rises, so
// one item per cycle is sustained. Each result is registered through stages 1 to 6 and is shown
// for one cycle, marked by done; the restoring divider in stage 4 spends one pipeline stage
// per quotient bit (FRAC_BITS+1 stages). The receiver cannot stall.
// The PWM period register is written on the cfg channel, which is always ready; write it
// only while no item is in flight.
module space_vector_pwm_modulator #(
	parameter int VOLT_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire signed [VOLT_BITS-1:0] v_alpha,
	input  wire signed [VOLT_BITS-1:0] v_beta,
	input  wire [VOLT_BITS-1:0]        v_bus,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [15:0]                 cfg_data,
	output logic                       done,
	output logic [15:0]                duty_u,
	output logic [15:0]                duty_v,
	output logic [15:0]                duty_w,
	output logic [2:0]                 sector,
	output logic                       overmodulated,
	output logic                       bus_error
);
	import svpwm_pkg::*;

	localparam int PW = VOLT_BITS + 32;
	localparam int NW = PW - 1;
	localparam int SW = PW;
	localparam int SQW = 2 * VOLT_BITS;
	localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE_M1 = (FRAC_BITS+1)'((1 << FRAC_BITS) - 1);

	typedef struct packed {
		logic [SW-1:0] den;
		logic [2:0]    sec;
		logic          over;
		logic          err;
	} side_t;

	logic [15:0] period_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= cfg_data;
		end
	end

	// Stage 1: squares for the exact sector test and the sqrt3 product.
	logic                       valid_s1;
	logic signed [VOLT_BITS-1:0] va_s1, vb_s1;
	logic [VOLT_BITS-1:0]       vbus_s1;
	logic [SQW-1:0]             sqa_s1, sqb_s1;
	logic signed [VOLT_BITS+29:0] rvb_s1;
	logic signed [SQW-1:0]      sqa_w, sqb_w;

	assign sqa_w = v_alpha * v_alpha;
	assign sqb_w = v_beta * v_beta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		va_s1 <= v_alpha;
		vb_s1 <= v_beta;
		vbus_s1 <= v_bus;
		sqa_s1 <= sqa_w;
		sqb_s1 <= sqb_w;
		rvb_s1 <= SQRT3_Q28 * v_beta;
	end

	// Stage 2: projections and sector.
	logic                 valid_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2;
	logic [2:0]           sec_s2;
	logic [VOLT_BITS-1:0] vbus_s2;
	logic signed [PW-1:0] vae, rvbe, a3;
	logic [SQW+1:0]       x2, y2;
	logic                 gt, lt, vb_pos, vb_nneg, va_nneg, va_npos, va_pos, line_a, line_b;
	logic [2:0]           sec_w;

	always_comb begin
		vae = PW'(va_s1);
		rvbe = PW'(rvb_s1);
		a3 = (vae <<< 28) + (vae <<< 29);
		x2 = (SQW+2)'(sqa_s1) + ((SQW+2)'(sqa_s1) << 1);
		y2 = (SQW+2)'(sqb_s1);
		gt = y2 > x2;
		lt = y2 < x2;
		vb_pos = (vb_s1 > 0);
		vb_nneg = (vb_s1 >= 0);
		va_pos = (va_s1 > 0);
		va_nneg = (va_s1 >= 0);
		va_npos = (va_s1 <= 0);
		// line_a is true when the vector lies above the line through the origin at +60 degrees, line_b at -60 degrees.
		line_a = va_nneg ? (vb_nneg && gt) : (vb_nneg || lt);
		line_b = va_npos ? (vb_nneg && gt) : (vb_nneg || lt);
		if (va_s1 == 0 && vb_s1 == 0) begin
			sec_w = SEC_1;
		end else if (vb_pos || (vb_s1 == 0 && va_pos)) begin
			sec_w = !line_a ? SEC_1 : (line_b ? SEC_2 : SEC_3);
		end else begin
			sec_w = line_a ? SEC_4 : (line_b ? SEC_6 : SEC_5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2 <= rvbe <<< 1;
		p2_s2 <= a3 + rvbe;
		p3_s2 <= rvbe - a3;
		sec_s2 <= sec_w;
		vbus_s2 <= vbus_s1;
	end

	// Stage 3: pick the two numerators and the common divisor.
	logic          valid_s3;
	logic [NW-1:0] n1_s3, n2_s3;
	side_t         side_s3;
	logic signed [PW-1:0] sn1, sn2;
	logic [NW-1:0] n1_w, n2_w;
	logic [SW-1:0] sum_w, dbus_w;
	logic          over_w;

	always_comb begin
		unique case (sec_s2)
			SEC_1: begin sn1 = -p3_s2; sn2 = p1_s2; end
			SEC_2: begin sn1 = p2_s2; sn2 = p3_s2; end
			SEC_3: begin sn1 = p1_s2; sn2 = -p2_s2; end
			SEC_4: begin sn1 = p3_s2; sn2 = -p1_s2; end
			SEC_5: begin sn1 = -p2_s2; sn2 = -p3_s2; end
			default: begin sn1 = -p1_s2; sn2 = p2_s2; end
		endcase
		// A slightly negative numerator from the rounded sqrt3 counts as zero.
		n1_w = sn1[PW-1] ? '0 : sn1[NW-1:0];
		n2_w = sn2[PW-1] ? '0 : sn2[NW-1:0];
		sum_w = SW'(n1_w) + SW'(n2_w);
		dbus_w = SW'(vbus_s2) << NUM_SHIFT;
		over_w = sum_w > dbus_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		n1_s3 <= n1_w;
		n2_s3 <= n2_w;
		side_s3.den <= over_w ? sum_w : dbus_w;
		side_s3.sec <= sec_s2;
		side_s3.over <= over_w;
		side_s3.err <= (vbus_s2 == '0);
	end

	// Stage 4: restoring divider, one quotient bit per stage, two lanes in parallel.
	logic            valid_s4 [FRAC_BITS+1];
	logic [SW:0]     r1_s4 [FRAC_BITS+1];
	logic [SW:0]     r2_s4 [FRAC_BITS+1];
	logic [FRAC_BITS:0] q1_s4 [FRAC_BITS+1];
	logic [FRAC_BITS:0] q2_s4 [FRAC_BITS+1];
	side_t           side_s4 [FRAC_BITS+1];

	for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_div
		logic [SW:0] rin1, rin2, den;
		logic [FRAC_BITS:0] qin1, qin2;
		logic ge1, ge2, vin;
		side_t sin;

		if (k == 0) begin : g_head
			assign rin1 = (SW+1)'(n1_s3);
			assign rin2 = (SW+1)'(n2_s3);
			assign qin1 = '0;
			assign qin2 = '0;
			assign sin = side_s3;
			assign vin = valid_s3;
		end else begin : g_tail
			assign rin1 = {r1_s4[k-1][SW-1:0], 1'b0};
			assign rin2 = {r2_s4[k-1][SW-1:0], 1'b0};
			assign qin1 = q1_s4[k-1];
			assign qin2 = q2_s4[k-1];
			assign sin = side_s4[k-1];
			assign vin = valid_s4[k-1];
		end

		always_comb begin
			den = (SW+1)'(sin.den);
			ge1 = rin1 >= den;
			ge2 = rin2 >= den;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s4[k] <= 1'b0;
			end else begin
				valid_s4[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			r1_s4[k] <= ge1 ? rin1 - den : rin1;
			r2_s4[k] <= ge2 ? rin2 - den : rin2;
			q1_s4[k] <= {qin1[FRAC_BITS-1:0], ge1};
			q2_s4[k] <= {qin2[FRAC_BITS-1:0], ge2};
			side_s4[k] <= sin;
		end
	end

	// Stage 5: zero time and phase duties.
	logic               valid_s5;
	logic [FRAC_BITS:0] du_s5, dv_s5, dw_s5;
	logic [2:0]         sec_s5;
	logic               over_s5, err_s5;
	side_t              sl;
	logic [FRAC_BITS:0] t1, t2, t0, tf, ta, tb;
	logic [FRAC_BITS+1:0] rest;

	always_comb begin
		sl = side_s4[FRAC_BITS];
		// In scaling, a numerator equal to the sum saturates just below one.
		t1 = (sl.over && q1_s4[FRAC_BITS][FRAC_BITS]) ? ONE_M1 : q1_s4[FRAC_BITS];
		t2 = (sl.over && q2_s4[FRAC_BITS][FRAC_BITS]) ? ONE_M1 : q2_s4[FRAC_BITS];
		rest = ONE - (FRAC_BITS+2)'(t1) - (FRAC_BITS+2)'(t2);
		t0 = rest[FRAC_BITS+1:1];
		tf = t1 + t2 + t0;
		ta = t1 + t0;
		tb = t2 + t0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		unique case (sl.sec)
			SEC_1: begin du_s5 <= tf; dv_s5 <= tb; dw_s5 <= t0; end
			SEC_2: begin du_s5 <= ta; dv_s5 <= tf; dw_s5 <= t0; end
			SEC_3: begin du_s5 <= t0; dv_s5 <= tf; dw_s5 <= tb; end
			SEC_4: begin du_s5 <= t0; dv_s5 <= ta; dw_s5 <= tf; end
			SEC_5: begin du_s5 <= tb; dv_s5 <= t0; dw_s5 <= tf; end
			default: begin du_s5 <= tf; dv_s5 <= t0; dw_s5 <= ta; end
		endcase
		sec_s5 <= sl.sec;
		over_s5 <= sl.over;
		err_s5 <= sl.err;
	end

	// Stage 6: scale duties to timer ticks.
	logic        valid_s6;
	logic [15:0] du_s6, dv_s6, dw_s6;
	logic [2:0]  sec_s6;
	logic        over_s6, err_s6;
	logic [FRAC_BITS+16:0] pu, pv, pw;

	always_comb begin
		pu = du_s5 * period_q;
		pv = dv_s5 * period_q;
		pw = dw_s5 * period_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		du_s6 <= err_s5 ? 16'd0 : pu[FRAC_BITS+15:FRAC_BITS];
		dv_s6 <= err_s5 ? 16'd0 : pv[FRAC_BITS+15:FRAC_BITS];
		dw_s6 <= err_s5 ? 16'd0 : pw[FRAC_BITS+15:FRAC_BITS];
		sec_s6 <= err_s5 ? SEC_NONE : sec_s5;
		over_s6 <= over_s5 && !err_s5;
		err_s6 <= err_s5;
	end

	assign done = valid_s6;
	assign duty_u = du_s6;
	assign duty_v = dv_s6;
	assign duty_w = dw_s6;
	assign sector = sec_s6;
	assign overmodulated = over_s6;
	assign bus_error = err_s6;
endmodule
`default_nettype wire

/* hdl/svpwm_checker.sv */
// Port-level checker for the space vector PWM modulator, with its bind.
// Depends on svpwm_pkg for sector codes.
`default_nettype none
module svpwm_checker #(
	parameter int LATENCY = 22
) (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [15:0] duty_u,
	input wire [15:0] duty_v,
	input wire [15:0] duty_w,
	input wire [2:0]  sector,
	input wire        overmodulated,
	input wire        bus_error
);
	import svpwm_pkg::*;

	// Every accepted transfer yields its result after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after fixed latency");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bus_error) |-> (duty_u == 16'd0 && duty_v == 16'd0 && duty_w == 16'd0
			&& sector == SEC_NONE && !overmodulated))
		else $error("bus error result not cleared");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bus_error) |-> (sector == SEC_1 || sector == SEC_2 || sector == SEC_3
			|| sector == SEC_4 || sector == SEC_5 || sector == SEC_6))
		else $error("sector out of range");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule

bind space_vector_pwm_modulator svpwm_checker #(.LATENCY(FRAC_BITS + 6)) u_svpwm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.duty_u(duty_u),
	.duty_v(duty_v),
	.duty_w(duty_w),
	.sector(sector),
	.overmodulated(overmodulated),
	.bus_error(bus_error)
);
`default_nettype wire
